// File: rtl/psfc_pkg.sv
// package: pcm format codes shared by the converter files
package psfc_pkg;

  localparam int unsigned FMT_W = 3;

  localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_S24 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_S32 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_F32 = 3'd4;

  localparam logic [FMT_W-1:0] SRC_FMT_RESET = FMT_S16;
  localparam logic [FMT_W-1:0] DST_FMT_RESET = FMT_F32;

  localparam int unsigned SAMPLE_W = 32;

endpackage

// File: rtl/psfc_in_if.sv
// interface: input sample channel
interface psfc_in_if;
  import psfc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_bits;
  logic                last_in;

  modport source (output valid, output sample_bits, output last_in, input ready);
  modport sink (input valid, input sample_bits, input last_in, output ready);
endinterface

// File: rtl/psfc_out_if.sv
// interface: converted sample channel
interface psfc_out_if;
  import psfc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] converted_bits;
  logic                last_out;

  modport source (output valid, output converted_bits, output last_out, input ready);
  modport sink (input valid, input converted_bits, input last_out, output ready);
endinterface

// File: rtl/pcm_sample_format_converter.sv
// top level: five-stage pcm sample format converter with apb register port
// in_ch takes one raw sample per item (low bytes, little-endian assembled)
// plus a last flag; out_ch returns the sample re-encoded in the target
// format, upper bits zero, with the last flag copied.
// registers: 0x0 source_format, 0x4 target_format (codes 0 u8, 1 s16,
// 2 s24, 3 s32, 4 f32); the user must see that they are written through
// the apb port only while idle: the block itself does not enforce this.
// throughput: one item per cycle while out_ch does not stall; the five
// register stages (decode, normalize, round, align shift, final round and
// saturate) each hold one item, so a new item enters every cycle unless stalled.
// stall: the whole pipe holds when a result waits on out_ch and
// out_ch.ready is low; in_ch.ready drops in that cycle, nothing is lost.
// reset (rst_n low, synchronous): all stage valid bits clear, source
// format returns to s16 and target format to f32.
module pcm_sample_format_converter
  import psfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  psfc_in_if.sink     in_ch,
  psfc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef struct packed {
    logic             last;
    logic [FMT_W-1:0] dst;
    logic             direct;
    logic [31:0]      dval;
    logic             sgn;
    logic [31:0]      mag;
    logic [7:0]       fexp;
    logic [5:0]       ksrc;
    logic             is_flt;
  } st1_t;

  typedef struct packed {
    logic             last;
    logic [FMT_W-1:0] dst;
    logic             direct;
    logic [31:0]      dval;
    logic             sgn;
    logic [31:0]      norm;
    logic [4:0]       lz;
    logic             zero;
    logic [5:0]       ksrc;
    logic [7:0]       fexp;
    logic [22:0]      frac;
    logic             is_flt;
  } st2_t;

  typedef struct packed {
    logic             last;
    logic [FMT_W-1:0] dst;
    logic             direct;
    logic [31:0]      dval;
    logic             sgn;
    logic [23:0]      m;
    logic [8:0]       e;
    logic             zero;
  } st3_t;

  typedef struct packed {
    logic             last;
    logic [FMT_W-1:0] dst;
    logic             direct;
    logic [31:0]      dval;
    logic [31:0]      fbits;
    logic             sgn;
    logic [33:0]      pint;
    logic             g;
    logic             st;
  } st4_t;

  logic [FMT_W-1:0] src_fmt_r, dst_fmt_r;
  logic             s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  st1_t             s1_r, s1_nxt;
  st2_t             s2_r, s2_nxt;
  st3_t             s3_r, s3_nxt;
  st4_t             s4_r, s4_nxt;
  logic [31:0]      conv_r, conv_nxt;
  logic             last_r;
  logic [FMT_W-1:0] odst_r;
  logic             adv;
  logic             cfg_wr;

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {29'b0, dst_fmt_r} : {29'b0, src_fmt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= SRC_FMT_RESET;
      dst_fmt_r <= DST_FMT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) dst_fmt_r <= pwdata[FMT_W-1:0];
      else          src_fmt_r <= pwdata[FMT_W-1:0];
    end
  end

  // whole pipe moves unless a result is held at the output
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 1: decode ----------------
  always_comb begin
    logic [31:0] raw, smask, dmask, sv, iv;
    logic        bad, eq, ii;
    logic [4:0]  sh;
    raw   = in_ch.sample_bits;
    sh    = 5'd0;
    bad   = (src_fmt_r > FMT_F32) || (dst_fmt_r > FMT_F32);
    eq    = (src_fmt_r == dst_fmt_r);
    ii    = (src_fmt_r == FMT_S16 || src_fmt_r == FMT_S24 || src_fmt_r == FMT_S32) &&
            (dst_fmt_r == FMT_S16 || dst_fmt_r == FMT_S24 || dst_fmt_r == FMT_S32);
    case (src_fmt_r)
      FMT_U8:  smask = 32'h0000_00FF;
      FMT_S16: smask = 32'h0000_FFFF;
      FMT_S24: smask = 32'h00FF_FFFF;
      default: smask = 32'hFFFF_FFFF;
    endcase
    case (dst_fmt_r)
      FMT_U8:  dmask = 32'h0000_00FF;
      FMT_S16: dmask = 32'h0000_FFFF;
      FMT_S24: dmask = 32'h00FF_FFFF;
      default: dmask = 32'hFFFF_FFFF;
    endcase
    sv = raw & smask;
    s1_nxt.last   = in_ch.last_in;
    s1_nxt.dst    = dst_fmt_r;
    s1_nxt.direct = bad || eq || ii;
    if (bad) begin
      s1_nxt.dval = 32'h0;
    end else if (eq) begin
      s1_nxt.dval = sv;
    end else if (dst_fmt_r > src_fmt_r) begin
      sh = {dst_fmt_r[1:0] - src_fmt_r[1:0], 3'b000};
      s1_nxt.dval = (sv << sh) & dmask;
    end else begin
      sh = {src_fmt_r[1:0] - dst_fmt_r[1:0], 3'b000};
      s1_nxt.dval = (sv >> sh) & dmask;
    end
    case (src_fmt_r)
      FMT_U8: begin
        iv = {24'h0, raw[7:0]} - 32'd128;
        s1_nxt.ksrc = 6'd7;
      end
      FMT_S16: begin
        iv = {{16{raw[15]}}, raw[15:0]};
        s1_nxt.ksrc = 6'd15;
      end
      FMT_S24: begin
        iv = {{8{raw[23]}}, raw[23:0]};
        s1_nxt.ksrc = 6'd23;
      end
      default: begin
        iv = raw;
        s1_nxt.ksrc = 6'd31;
      end
    endcase
    s1_nxt.is_flt = (src_fmt_r == FMT_F32);
    s1_nxt.fexp   = raw[30:23];
    if (s1_nxt.is_flt) begin
      s1_nxt.sgn = raw[31];
      s1_nxt.mag = {9'h0, raw[22:0]};
    end else begin
      s1_nxt.sgn = iv[31];
      s1_nxt.mag = iv[31] ? (~iv + 32'd1) : iv;
    end
  end

  // ---------------- stage 2: leading-zero normalize ----------------
  always_comb begin
    logic [31:0] n;
    logic [4:0]  lz;
    n  = s1_r.mag;
    lz = 5'd0;
    if (n[31:16] == 16'h0) begin n = n << 16; lz[4] = 1'b1; end
    if (n[31:24] == 8'h0)  begin n = n << 8;  lz[3] = 1'b1; end
    if (n[31:28] == 4'h0)  begin n = n << 4;  lz[2] = 1'b1; end
    if (n[31:30] == 2'h0)  begin n = n << 2;  lz[1] = 1'b1; end
    if (n[31] == 1'b0)     begin n = n << 1;  lz[0] = 1'b1; end
    s2_nxt.last   = s1_r.last;
    s2_nxt.dst    = s1_r.dst;
    s2_nxt.direct = s1_r.direct;
    s2_nxt.dval   = s1_r.dval;
    s2_nxt.sgn    = s1_r.sgn;
    s2_nxt.norm   = n;
    s2_nxt.lz     = lz;
    s2_nxt.zero   = (s1_r.mag == 32'h0);
    s2_nxt.ksrc   = s1_r.ksrc;
    s2_nxt.fexp   = s1_r.fexp;
    s2_nxt.frac   = s1_r.mag[22:0];
    s2_nxt.is_flt = s1_r.is_flt;
  end

  // ---------------- stage 3: round to 24 bits / unpack float ----------------
  always_comb begin
    logic [23:0] mant;
    logic [24:0] msum;
    logic        up;
    mant = s2_r.norm[31:8];
    up   = s2_r.norm[7] && ((|s2_r.norm[6:0]) || mant[0]);
    msum = {1'b0, mant} + {24'h0, up};
    s3_nxt.last   = s2_r.last;
    s3_nxt.dst    = s2_r.dst;
    s3_nxt.direct = s2_r.direct;
    s3_nxt.dval   = s2_r.dval;
    s3_nxt.sgn    = s2_r.sgn;
    if (s2_r.is_flt) begin
      s3_nxt.m    = {(s2_r.fexp != 8'h0), s2_r.frac};
      s3_nxt.e    = (s2_r.fexp == 8'h0) ? 9'h182 : ({1'b0, s2_r.fexp} - 9'd127);
      // nan reads as zero
      s3_nxt.zero = (s2_r.fexp == 8'hFF) && (s2_r.frac != 23'h0);
    end else begin
      s3_nxt.m    = msum[24] ? 24'h80_0000 : msum[23:0];
      s3_nxt.e    = 9'd31 - {4'h0, s2_r.lz} - {3'h0, s2_r.ksrc} + {8'h0, msum[24]};
      s3_nxt.zero = s2_r.zero;
    end
  end

  // ---------------- stage 4: clamp, pack float, align shift ----------------
  always_comb begin
    logic [23:0] mz, mc;
    logic [8:0]  ec;
    logic [9:0]  off, d;
    logic [5:0]  lsh;
    logic [59:0] sx;
    logic        cl;
    mz = s3_r.zero ? 24'h0 : s3_r.m;
    cl = !s3_r.zero &&
         (($signed(s3_r.e) > 9'sd0) || ((s3_r.e == 9'h0) && (mz[22:0] != 23'h0)));
    mc = cl ? 24'h80_0000 : mz;
    ec = cl ? 9'h0 : s3_r.e;
    case (s3_r.dst)
      FMT_U8:  off = 10'd1;
      FMT_S16: off = 10'h3F9;
      FMT_S24: off = 10'd1;
      FMT_S32: off = 10'd9;
      default: off = 10'd0;
    endcase
    d   = {ec[8], ec} + off;
    lsh = 6'(d + 10'd26);
    sx  = {36'h0, mc} << lsh;
    s4_nxt.last   = s3_r.last;
    s4_nxt.dst    = s3_r.dst;
    s4_nxt.direct = s3_r.direct;
    s4_nxt.dval   = s3_r.dval;
    s4_nxt.sgn    = s3_r.sgn;
    s4_nxt.fbits  = s3_r.zero ? 32'h0 :
                    {s3_r.sgn, 8'(s3_r.e + 9'd127), s3_r.m[22:0]};
    // everything below the grid goes to sticky
    if ($signed(d) < -10'sd26) begin
      s4_nxt.pint = 34'h0;
      s4_nxt.g    = 1'b0;
      s4_nxt.st   = |mc;
    end else begin
      s4_nxt.pint = sx[59:26];
      s4_nxt.g    = sx[25];
      s4_nxt.st   = |sx[24:0];
    end
  end

  // ---------------- stage 5: round, saturate, select ----------------
  always_comb begin
    logic [34:0] xs;
    logic [33:0] magr;
    logic [31:0] sval, neg, smax, smsk;
    logic        sat;
    logic [24:0] y;
    logic [25:0] bq, bsum, cq, csum;
    logic [9:0]  up;
    logic [8:0]  k;
    logic [7:0]  u8v;
    xs   = {1'b0, s4_r.pint} + 35'd1;
    magr = xs[34:1];
    neg  = ~magr[31:0] + 32'd1;
    case (s4_r.dst)
      FMT_S16: begin sat = magr[15]; smax = 32'h0000_7FFF; smsk = 32'h0000_FFFF; end
      FMT_S24: begin sat = magr[23]; smax = 32'h007F_FFFF; smsk = 32'h00FF_FFFF; end
      default: begin sat = magr[31]; smax = 32'h7FFF_FFFF; smsk = 32'hFFFF_FFFF; end
    endcase
    if (!s4_r.sgn && sat) sval = smax;
    else                  sval = (s4_r.sgn ? neg : magr[31:0]) & smsk;
    // u8 target: float add of 128 rounds to 2^-16 above 128, 2^-17 below
    y    = s4_r.pint[24:0];
    bq   = {2'b0, y[24:1]} + {25'h0, y[0] && (s4_r.g || s4_r.st || y[1])};
    bsum = bq + 26'h000_8000;
    up   = 10'd128 + {1'b0, bsum[24:16]};
    cq   = {1'b0, y} + {25'h0, s4_r.g && (s4_r.st || y[0])};
    csum = cq + 26'h000_FFFF;
    k    = csum[25:17];
    if (s4_r.sgn) u8v = 8'(9'd128 - k);
    else          u8v = (up > 10'd255) ? 8'hFF : up[7:0];
    if (s4_r.direct)               conv_nxt = s4_r.dval;
    else if (s4_r.dst == FMT_F32)  conv_nxt = s4_r.fbits;
    else if (s4_r.dst == FMT_U8)   conv_nxt = {24'h0, u8v};
    else                           conv_nxt = sval;
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_ch.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      s3_r   <= s3_nxt;
      s4_r   <= s4_nxt;
      conv_r <= conv_nxt;
      last_r <= s4_r.last;
      odst_r <= s4_r.dst;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.converted_bits = conv_r;
  assign out_ch.last_out       = last_r;

`ifndef ASSERT_OFF
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_vld_r)
    else $error("accepted item did not enter stage 1");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

  a_u8_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (odst_r == FMT_U8) |-> (out_ch.converted_bits[31:8] == 24'h0))
    else $error("u8 result has upper bits set");
`endif

endmodule

// File: tb/tb_pcm_sample_format_converter.sv
// testbench: pcm format converter checked against a behavioral predictor over all format pairs
`timescale 1ns / 100ps

module tb_pcm_sample_format_converter;
  import psfc_pkg::*;

  localparam logic [2:0] REG_SRC_FMT = 3'h0;
  localparam logic [2:0] REG_DST_FMT = 3'h4;
  localparam int unsigned PIPE_DEPTH = 5;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned NUM_EDGES = 22;

  typedef struct {
    logic [SAMPLE_W-1:0] bits;
    logic                last;
  } sample_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  psfc_in_if  in_ch ();
  psfc_out_if out_ch ();

  pcm_sample_format_converter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sample_t           sample_q[$];
  sample_t           converted_q[$];
  logic [FMT_W-1:0]  src_fmt;
  logic [FMT_W-1:0]  dst_fmt;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  logic              send_hold;
  logic              hold_go;
  int unsigned       hold_left;
  int unsigned       cycle_count;
  int unsigned       error_count;
  logic [31:0]       edge_vals [NUM_EDGES];

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------- predictor ----------------

  function automatic real pow2(int k);
    logic [10:0] e;
    e = 11'(k + 1023);
    return $bitstoreal({1'b0, e, 52'b0});
  endfunction

  // round a double to the nearest binary32 value, ties to even (normal range)
  function automatic real round_binary32(real d);
    logic [63:0] w;
    logic [28:0] low;
    if (d == 0.0) return 0.0;
    w = $realtobits(d);
    low = w[28:0];
    w[28:0] = '0;
    if (low > 29'h1000_0000 || (low == 29'h1000_0000 && w[29])) w = w + 64'h2000_0000;
    return $bitstoreal(w);
  endfunction

  function automatic logic [31:0] binary32_bits(real x);
    logic [63:0] w;
    logic [7:0]  e;
    if (x == 0.0) return 32'h0;
    w = $realtobits(x);
    e = 8'(int'(w[62:52]) - 1023 + 127);
    return {w[63], e, w[51:29]};
  endfunction

  function automatic longint round_half_away(real d);
    real    tr;
    longint r;
    tr = (d >= 0.0) ? $floor(d) : $ceil(d);
    if (d - tr >= 0.5) tr = tr + 1.0;
    else if (d - tr <= -0.5) tr = tr - 1.0;
    r = tr;
    return r;
  endfunction

  // normalized value of the raw sample; nan reads as zero, infinities as +-2
  function automatic real normalized_value(logic [FMT_W-1:0] fmt, logic [31:0] raw);
    longint      m;
    int unsigned sh;
    longint      low;
    longint      half;
    longint      q;
    real         v;
    case (fmt)
      FMT_U8:  return (real'(int'(raw[7:0])) - 128.0) / 128.0;
      FMT_S16: return real'($signed(raw[15:0])) / 32768.0;
      FMT_S24: return real'($signed(raw[23:0])) / 8388608.0;
      FMT_S32: begin
        m = longint'($signed(raw));
        if (m < 0) m = -m;
        // keep 24 significant bits, ties to even
        if (m >= 64'h100_0000) begin
          sh = 0;
          while ((m >> sh) >= 64'h100_0000) sh++;
          low = m & ((64'd1 << sh) - 1);
          half = 64'd1 << (sh - 1);
          q = m >> sh;
          if (low > half || (low == half && q[0])) q++;
          m = q << sh;
        end
        v = real'(m) / 2147483648.0;
        return raw[31] ? -v : v;
      end
      default: begin
        if (raw[30:23] == 8'hFF) begin
          if (raw[22:0] != 0) return 0.0;
          return raw[31] ? -2.0 : 2.0;
        end
        if (raw[30:23] == 8'h00) v = real'(raw[22:0]) * pow2(-149);
        else v = real'({1'b1, raw[22:0]}) * pow2(int'(raw[30:23]) - 150);
        return raw[31] ? -v : v;
      end
    endcase
  endfunction

  function automatic logic [31:0] width_mask(logic [FMT_W-1:0] fmt);
    case (fmt)
      FMT_U8:  return 32'hFF;
      FMT_S16: return 32'hFFFF;
      FMT_S24: return 32'hFF_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] sample_convert(logic [FMT_W-1:0] src, logic [FMT_W-1:0] dst,
                                                 logic [31:0] raw);
    int unsigned sbits;
    int unsigned dbits;
    logic [31:0] v;
    real         x;
    real         t;
    longint      r;
    if (src > FMT_F32 || dst > FMT_F32) return 32'h0;
    if (src == dst) return raw & width_mask(src);
    if (src != FMT_U8 && src != FMT_F32 && dst != FMT_U8 && dst != FMT_F32) begin
      sbits = 8 * (src + 1);
      dbits = 8 * (dst + 1);
      v = raw & width_mask(src);
      if (dbits > sbits) v = v << (dbits - sbits);
      else v = v >> (sbits - dbits);
      return v & width_mask(dst);
    end
    x = normalized_value(src, raw);
    if (dst == FMT_F32) return binary32_bits(x);
    if (x < -1.0) x = -1.0;
    if (x > 1.0) x = 1.0;
    case (dst)
      FMT_U8: begin
        // the offset add rounds in single precision
        t = round_binary32(x * 128.0 + 128.0);
        r = round_half_away(t);
        if (r < 0) r = 0;
        if (r > 255) r = 255;
        return 32'(r);
      end
      FMT_S16: begin
        r = round_half_away(x * 32768.0);
        if (r < -32768) r = -32768;
        if (r > 32767) r = 32767;
        return 32'(r) & 32'hFFFF;
      end
      FMT_S24: begin
        r = round_half_away(x * 8388608.0);
        if (r < -8388608) r = -8388608;
        if (r > 8388607) r = 8388607;
        return 32'(r) & 32'hFF_FFFF;
      end
      default: begin
        r = round_half_away(x * 2147483648.0);
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        return 32'(r);
      end
    endcase
  endfunction

  // ---------------- input driver ----------------

  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        converted_q.push_back('{sample_convert(src_fmt, dst_fmt, in_ch.sample_bits),
                                in_ch.last_in});
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_q.size() > 0 && !send_hold && $urandom_range(0, 99) >= send_idle_pct) begin
          s = sample_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.sample_bits <= s.bits;
          in_ch.last_in     <= s.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (converted_q.size() == 0) begin
        $display("%0t: unexpected item bits=%h last=%b", $time, out_ch.converted_bits,
                 out_ch.last_out);
        error_count++;
      end else begin
        want = converted_q.pop_front();
        if (out_ch.converted_bits !== want.bits) begin
          $display("%0t: converted_bits expected %h actual %h", $time, want.bits,
                   out_ch.converted_bits);
          error_count++;
        end
        if (out_ch.last_out !== want.last) begin
          $display("%0t: last_out expected %b actual %b", $time, want.last, out_ch.last_out);
          error_count++;
        end
      end
    end
    if (hold_left > 0) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) hold_left <= 300;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pcm_sample_format_converter regression: fail");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_SRC_FMT) src_fmt = data[FMT_W-1:0];
    else dst_fmt = data[FMT_W-1:0];
  endtask

  task automatic wait_drained();
    while (sample_q.size() > 0 || in_ch.valid || converted_q.size() > 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample(logic [FMT_W-1:0] fmt);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return edge_vals[$urandom_range(0, NUM_EDGES - 1)];
    // mostly floats near the [-1,1] range
    if (fmt == FMT_F32 && pick < 8)
      return {1'($urandom_range(0, 1)), 8'($urandom_range(96, 128)), 23'($urandom)};
    return $urandom;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n;
    logic [FMT_W-1:0] s_sel;
    logic [FMT_W-1:0] d_sel;

    edge_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0080,
                  32'h0000_007F, 32'h0000_7FFF, 32'h0000_8000, 32'h007F_FFFF, 32'h0080_0000,
                  32'h0000_0001, 32'hFFFF_FF00, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
                  32'hFF80_0000, 32'h7FC0_0000, 32'h3F00_0000, 32'hC200_0000, 32'h0100_0003,
                  32'h0100_0001, 32'h807F_FFFF};
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_bits = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready = 1'b0;
    src_fmt = SRC_FMT_RESET;
    dst_fmt = DST_FMT_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_hold = 1'b0;
    hold_go = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    error_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // edge values under the reset formats
    for (int i = 0; i < NUM_EDGES; i++) sample_q.push_back('{edge_vals[i], 1'(i % 3 == 0)});
    wait_drained();

    for (phase = 0; phase < 28; phase++) begin
      if (phase < 25) begin
        s_sel = FMT_W'(phase / 5);
        d_sel = FMT_W'(phase % 5);
      end else if (phase == 25) begin
        s_sel = 3'd5;
        d_sel = FMT_S16;
      end else if (phase == 26) begin
        s_sel = FMT_S24;
        d_sel = 3'd6;
      end else begin
        s_sel = 3'd7;
        d_sel = 3'd7;
      end
      cfg_write(REG_SRC_FMT, {29'($urandom), s_sel});
      cfg_write(REG_DST_FMT, {29'($urandom), d_sel});
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      n = (s_sel == FMT_F32 || d_sel == FMT_U8) ? 80 : 55;
      for (int i = 0; i < n; i++)
        sample_q.push_back('{rand_sample(s_sel), 1'($urandom_range(0, 7) == 0)});
      if (phase == 4) begin
        // stall the output long enough for the pipe to back up
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      if (phase == 13) begin
        repeat (20) @(posedge clk);
        send_hold = 1'b1;
        while (converted_q.size() > 0 || in_ch.valid) @(posedge clk);
        send_hold = 1'b0;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("pcm_sample_format_converter regression: pass");
    end else begin
      $display("pcm_sample_format_converter regression: fail");
    end
    $finish;
  end

endmodule
